// File: rtl/ps2md_pkg.sv
// Package for the PS/2 mouse device block: types, constants and packet helpers.
`default_nettype none
package ps2md_pkg;

  localparam int AccLimit = 2048;
  localparam int AccW = $clog2(AccLimit) + 1;
  // scaled packet values reach twice the counter range, plus the negated minimum
  localparam int ScW = AccW + 2;
  localparam int MaxBytes = 5;
  localparam int CntW = 3;

  typedef enum logic [1:0] {
    OP_HOST   = 2'd0,
    OP_MOTION = 2'd1,
    OP_FRAME  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RES  = 2'd1,
    PEND_RATE = 2'd2
  } pend_t;

  localparam logic [1:0] PROTO_STD   = 2'd0;
  localparam logic [1:0] PROTO_WHEEL = 2'd1;
  localparam logic [1:0] PROTO_FIVE  = 2'd2;

  localparam logic [0:0] REG_MAX_PROTOCOL = 1'b0;
  localparam logic [0:0] REG_FORCE_SQUISH = 1'b1;

  localparam logic [7:0] BYTE_ACK  = 8'hFA;
  localparam logic [7:0] BYTE_BAT  = 8'hAA;
  localparam logic [7:0] CMD_SETRES  = 8'hE8;
  localparam logic [7:0] CMD_SCALE1  = 8'hE6;
  localparam logic [7:0] CMD_SCALE2  = 8'hE7;
  localparam logic [7:0] CMD_STATUS  = 8'hE9;
  localparam logic [7:0] CMD_STREAM  = 8'hEA;
  localparam logic [7:0] CMD_READ    = 8'hEB;
  localparam logic [7:0] CMD_WRAPOFF = 8'hEC;
  localparam logic [7:0] CMD_WRAPON  = 8'hEE;
  localparam logic [7:0] CMD_REMOTE  = 8'hF0;
  localparam logic [7:0] CMD_GETID   = 8'hF2;
  localparam logic [7:0] CMD_SETRATE = 8'hF3;
  localparam logic [7:0] CMD_ENABLE  = 8'hF4;
  localparam logic [7:0] CMD_DISABLE = 8'hF5;
  localparam logic [7:0] CMD_DEFAULT = 8'hF6;
  localparam logic [7:0] CMD_DEV_RESET = 8'hFF;

  localparam logic [7:0] RATE_DEFAULT = 8'd100;
  localparam logic [3:0] RES_DEFAULT  = 4'd4;

  // one stage of the result buffer
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [MaxBytes-1:0][7:0] bytes;
  } obuf_t;

  // map protocol select to the ID byte
  function automatic logic [7:0] proto_id(input logic [1:0] p);
    case (p)
      PROTO_WHEEL: proto_id = 8'd3;
      PROTO_FIVE:  proto_id = 8'd4;
      default:     proto_id = 8'd0;
    endcase
  endfunction

  // 2:1 scaling table for small counts, doubling elsewhere
  function automatic logic signed [ScW-1:0] scale21(input logic signed [ScW-1:0] d);
    case (d)
      -ScW'(5): scale21 = -ScW'(9);
      -ScW'(4): scale21 = -ScW'(6);
      -ScW'(3): scale21 = -ScW'(3);
      -ScW'(2): scale21 = -ScW'(1);
      -ScW'(1): scale21 = -ScW'(1);
      ScW'(1):  scale21 = ScW'(1);
      ScW'(2):  scale21 = ScW'(1);
      ScW'(3):  scale21 = ScW'(3);
      ScW'(4):  scale21 = ScW'(6);
      ScW'(5):  scale21 = ScW'(9);
      default:  scale21 = d <<< 1;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/ps2md_out.sv
// Result buffer: holds one item's bytes and streams them out one beat each.
`default_nettype none
module ps2md_out
  import ps2md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire obuf_t       load_data,
  output logic             busy,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // out_byte
  output logic             out_tlast
);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;
  logic [MaxBytes-1:0][7:0] bytes_r;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = bytes_r[pos_r];
  assign out_tlast  = (pos_r == cnt_r - CntW'(1));
  assign busy       = out_tvalid && !(out_tready && out_tlast);

  // advance position per beat, reload when the run is done
  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (out_tvalid && out_tready) begin
      if (out_tlast) begin
        cnt_nxt = '0;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + CntW'(1);
      end
    end
    if (load) begin
      cnt_nxt = load_data.cnt;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bytes_r <= load_data.bytes;
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pos_r < cnt_r) else $error("position beyond count");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxBytes)) else $error("byte count too large");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy) else $error("load while run in progress");

endmodule
`default_nettype wire

// File: rtl/ps2_mouse_device_top.sv
// Top level of the PS/2 mouse device: command handling, counters and packet build.
// Path: an input register holds each item, then the result buffer sends its bytes.
// Throughput: one item per cycle for items that give no bytes, once earlier bytes
// are out; an item of n bytes (up to 5) holds the output for n serializer beats.
// Reset: synchronous active-low rst_n restores all mode state and clears the counters.
`default_nettype none
module ps2_mouse_device_top
  import ps2md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // host_byte, move_x, move_y, move_wheel,
                                       // button_bits
  input  wire logic [1:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [1:0]  cfg_wdata
);

  // configuration
  logic [1:0] max_protocol_r;
  logic       force_squish_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_protocol_r <= '0;
      force_squish_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_PROTOCOL: max_protocol_r <= cfg_wdata;
        REG_FORCE_SQUISH: force_squish_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  logic        iv_r;
  logic [38:0] id_r;
  logic [1:0]  iu_r;
  logic        obusy;

  assign in_tready = !iv_r || !obusy;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      id_r <= in_tdata[38:0];
      iu_r <= in_tuser;
    end
  end

  // the input stage only moves when the output can take it
  logic fire;
  assign fire = iv_r && !obusy;

  // unpack fields
  logic [1:0]        f_op;
  logic [7:0]        f_hb;
  logic signed [8:0] f_mx, f_my;
  logic signed [7:0] f_mw;
  logic [4:0]        f_btn;
  assign f_op  = iu_r;
  assign f_hb  = id_r[7:0];
  assign f_mx  = id_r[16:8];
  assign f_my  = id_r[25:17];
  assign f_mw  = id_r[33:26];
  assign f_btn = id_r[38:34];

  // state
  logic signed [AccW-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic signed [7:0] acc_w_r, acc_w_nxt;
  logic [4:0] btn_r, btn_nxt;
  logic [1:0] proto_r, proto_nxt, uw_r, uw_nxt, uf_r, uf_nxt;
  logic [7:0] rate_r, rate_nxt;
  logic [3:0] res_r, res_nxt;
  logic scale_r, scale_nxt, rep_r, rep_nxt, rem_r, rem_nxt, wrap_r, wrap_nxt;
  logic dr_r, dr_nxt;
  pend_t pend_r, pend_nxt;
  obuf_t ob;

  // visible buttons
  function automatic logic [4:0] vis(input logic [4:0] b, input logic sq,
                                     input logic [1:0] p);
    if (sq || p != PROTO_FIVE) vis = {2'b00, |b[4:2], b[1:0]};
    else vis = b;
  endfunction

  // packet build from current counters
  logic [7:0] pk_b0, pk_dx, pk_dy, pk_b3;
  logic       pk_scale;
  logic signed [ScW-1:0] dx0, dy0, dx1, dy1;
  logic [4:0] vb_cur;

  always_comb begin
    vb_cur = vis(btn_r, force_squish_r, proto_r);
    dx0 = ScW'(acc_x_r);
    dy0 = -ScW'(acc_y_r);
    dx1 = pk_scale ? scale21(dx0) : dx0;
    dy1 = pk_scale ? scale21(dy0) : dy0;
    pk_b0 = {5'b00001, vb_cur[2:0]};
    if (proto_r == PROTO_FIVE) begin
      if (dx1 > 255) dx1 = ScW'(255);
      if (dx1 < -255) dx1 = -ScW'(255);
      if (dy1 > 255) dy1 = ScW'(255);
      if (dy1 < -255) dy1 = -ScW'(255);
    end else begin
      if (dx1 > 255 || dx1 < -255) pk_b0[6] = 1'b1;
      if (dy1 > 255 || dy1 < -255) pk_b0[7] = 1'b1;
    end
    if (dx1 < 0) pk_b0[4] = 1'b1;
    if (dy1 < 0) pk_b0[5] = 1'b1;
    pk_dx = dx1[7:0];
    pk_dy = dy1[7:0];
    if (proto_r == PROTO_WHEEL) pk_b3 = acc_w_r;
    else if (acc_w_r > 7) pk_b3 = {2'b00, vb_cur[4:3], 4'h7};
    else if (acc_w_r < -8) pk_b3 = {2'b00, vb_cur[4:3], 4'h8};
    else pk_b3 = {2'b00, vb_cur[4:3], acc_w_r[3:0]};
  end

  // rate-parameter path: new rate and unlock progress
  logic [7:0] nr;
  logic       rate_ok;
  logic [1:0] uw_a, uf_a, pr_a;
  logic [7:0] sw, sf;

  always_comb begin
    rate_ok = (f_hb == 8'd10) || (f_hb == 8'd20) || (f_hb == 8'd40) ||
              (f_hb == 8'd60) || (f_hb == 8'd80) || (f_hb == 8'd100) ||
              (f_hb == 8'd200);
    nr   = rate_ok ? f_hb : RATE_DEFAULT;
    uw_a = rate_ok ? uw_r : 2'd0;
    uf_a = rate_ok ? uf_r : 2'd0;
    pr_a = proto_r;
    case (uw_a)
      2'd1:    sw = 8'd100;
      2'd2:    sw = 8'd80;
      default: sw = 8'd200;
    endcase
    if (max_protocol_r == 2'd1 || max_protocol_r == 2'd2) begin
      if (uw_a == 2'd3) uw_a = 2'd0;
      if (sw != nr) uw_a = 2'd0;
      else if (uw_a == 2'd2) begin
        pr_a = PROTO_WHEEL; uw_a = 2'd0; uf_a = 2'd0;
      end else uw_a = uw_a + 2'd1;
    end
    case (uf_a)
      2'd1:    sf = 8'd200;
      2'd2:    sf = 8'd80;
      default: sf = 8'd200;
    endcase
    if (max_protocol_r == 2'd2) begin
      if (uf_a == 2'd3) uf_a = 2'd0;
      if (sf != nr) uf_a = 2'd0;
      else if (uf_a == 2'd2) begin
        pr_a = PROTO_FIVE; uw_a = 2'd0; uf_a = 2'd0;
      end else uf_a = uf_a + 2'd1;
    end
  end

  // motion sums
  logic signed [AccW:0] sx, sy;
  logic signed [8:0]    sw9;
  always_comb begin
    sx  = (AccW+1)'(acc_x_r) + (AccW+1)'(f_mx);
    sy  = (AccW+1)'(acc_y_r) + (AccW+1)'(f_my);
    sw9 = 9'(acc_w_r) + 9'(f_mw);
  end

  // main next-state and result bytes
  always_comb begin
    acc_x_nxt = acc_x_r; acc_y_nxt = acc_y_r; acc_w_nxt = acc_w_r;
    btn_nxt = btn_r; proto_nxt = proto_r; uw_nxt = uw_r; uf_nxt = uf_r;
    rate_nxt = rate_r; res_nxt = res_r; scale_nxt = scale_r; rep_nxt = rep_r;
    rem_nxt = rem_r; wrap_nxt = wrap_r; dr_nxt = dr_r; pend_nxt = pend_r;
    ob = '0;
    pk_scale = 1'b0;
    case (opcode_t'(f_op))
      OP_HOST: begin
        if (wrap_r && f_hb != CMD_DEV_RESET && f_hb != CMD_WRAPOFF) begin
          ob.cnt = 3'd1; ob.bytes[0] = f_hb;
        end else begin
          ob.cnt = 3'd1; ob.bytes[0] = BYTE_ACK;
          if (pend_r != PEND_NONE) begin
            pend_nxt = PEND_NONE;
            acc_x_nxt = '0; acc_y_nxt = '0; acc_w_nxt = '0;
            if (pend_r == PEND_RES) begin
              uw_nxt = 2'd0; uf_nxt = 2'd0;
              res_nxt = (f_hb == 8'd1 || f_hb == 8'd2 || f_hb == 8'd4 ||
                         f_hb == 8'd8) ? f_hb[3:0] : RES_DEFAULT;
            end else begin
              rate_nxt = nr; uw_nxt = uw_a; uf_nxt = uf_a; proto_nxt = pr_a;
            end
          end else begin
            case (f_hb)
              CMD_SETRES:  pend_nxt = PEND_RES;
              CMD_SETRATE: pend_nxt = PEND_RATE;
              CMD_SCALE1: begin uw_nxt = '0; uf_nxt = '0; scale_nxt = 1'b0; end
              CMD_SCALE2: begin uw_nxt = '0; uf_nxt = '0; scale_nxt = 1'b1; end
              CMD_STATUS: begin
                ob.cnt = 3'd4;
                ob.bytes[1] = {1'b0, rem_r, rep_r, scale_r, 1'b0,
                               vb_cur[0], vb_cur[2], vb_cur[1]};
                ob.bytes[2] = {4'h0, res_r};
                ob.bytes[3] = rate_r;
              end
              CMD_READ: begin
                ob.cnt = (proto_r == PROTO_WHEEL || proto_r == PROTO_FIVE) ? 3'd5 : 3'd4;
                ob.bytes[1] = pk_b0; ob.bytes[2] = pk_dx; ob.bytes[3] = pk_dy;
                ob.bytes[4] = pk_b3;
                acc_x_nxt = '0; acc_y_nxt = '0; dr_nxt = 1'b0;
                if (proto_r == PROTO_WHEEL || proto_r == PROTO_FIVE) acc_w_nxt = '0;
              end
              CMD_STREAM, CMD_WRAPOFF, CMD_WRAPON, CMD_REMOTE, CMD_ENABLE,
              CMD_DISABLE: begin
                uw_nxt = '0; uf_nxt = '0;
                acc_x_nxt = '0; acc_y_nxt = '0; acc_w_nxt = '0;
                if (f_hb == CMD_STREAM) rem_nxt = 1'b0;
                if (f_hb == CMD_REMOTE) rem_nxt = 1'b1;
                if (f_hb == CMD_WRAPOFF) wrap_nxt = 1'b0;
                if (f_hb == CMD_WRAPON) wrap_nxt = 1'b1;
                if (f_hb == CMD_ENABLE) rep_nxt = 1'b1;
                if (f_hb == CMD_DISABLE) rep_nxt = 1'b0;
              end
              CMD_GETID: begin
                ob.cnt = 3'd2; ob.bytes[1] = proto_id(proto_r);
                acc_x_nxt = '0; acc_y_nxt = '0; acc_w_nxt = '0;
              end
              CMD_DEFAULT, CMD_DEV_RESET: begin
                // defaults: rate 100 and resolution 4; unlock progress is cleared with no unlock check
                res_nxt = RES_DEFAULT; rate_nxt = RATE_DEFAULT;
                uw_nxt = '0; uf_nxt = '0;
                scale_nxt = 1'b0; rep_nxt = 1'b0; rem_nxt = 1'b0; wrap_nxt = 1'b0;
                acc_x_nxt = '0; acc_y_nxt = '0; acc_w_nxt = '0;
                if (f_hb == CMD_DEV_RESET) begin
                  proto_nxt = PROTO_STD;
                  ob.cnt = 3'd3; ob.bytes[1] = BYTE_BAT; ob.bytes[2] = 8'h00;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_MOTION: begin
        if (sx > (AccW+1)'(AccLimit - 1)) acc_x_nxt = AccW'(AccLimit - 1);
        else if (sx < -(AccW+1)'(AccLimit)) acc_x_nxt = AccW'(-AccLimit);
        else acc_x_nxt = sx[AccW-1:0];
        if (sy > (AccW+1)'(AccLimit - 1)) acc_y_nxt = AccW'(AccLimit - 1);
        else if (sy < -(AccW+1)'(AccLimit)) acc_y_nxt = AccW'(-AccLimit);
        else acc_y_nxt = sy[AccW-1:0];
        if (acc_x_nxt != 0 || acc_y_nxt != 0) dr_nxt = 1'b1;
        btn_nxt = f_btn;
        if (vis(f_btn, force_squish_r, proto_r) != vb_cur) dr_nxt = 1'b1;
        if (proto_r == PROTO_WHEEL || proto_r == PROTO_FIVE) begin
          if (sw9 > 9'sd127) acc_w_nxt = 8'sd127;
          else if (sw9 < -9'sd128) acc_w_nxt = -8'sd128;
          else acc_w_nxt = sw9[7:0];
        end
        if (acc_w_nxt != acc_w_r) dr_nxt = 1'b1;
      end
      OP_FRAME: begin
        if (dr_r) begin
          pk_scale = scale_r;
          acc_x_nxt = '0; acc_y_nxt = '0; dr_nxt = 1'b0;
          if (proto_r == PROTO_WHEEL || proto_r == PROTO_FIVE) acc_w_nxt = '0;
          if (!wrap_r && !rem_r && rep_r) begin
            ob.cnt = (proto_r == PROTO_WHEEL || proto_r == PROTO_FIVE) ? 3'd4 : 3'd3;
            ob.bytes[0] = pk_b0; ob.bytes[1] = pk_dx; ob.bytes[2] = pk_dy;
            ob.bytes[3] = pk_b3;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0; acc_y_r <= '0; acc_w_r <= '0; btn_r <= '0;
      proto_r <= PROTO_STD; uw_r <= '0; uf_r <= '0;
      rate_r <= RATE_DEFAULT; res_r <= RES_DEFAULT;
      scale_r <= 1'b0; rep_r <= 1'b0; rem_r <= 1'b0; wrap_r <= 1'b0;
      pend_r <= PEND_NONE; dr_r <= 1'b0;
    end else if (fire) begin
      acc_x_r <= acc_x_nxt; acc_y_r <= acc_y_nxt; acc_w_r <= acc_w_nxt;
      btn_r <= btn_nxt; proto_r <= proto_nxt; uw_r <= uw_nxt; uf_r <= uf_nxt;
      rate_r <= rate_nxt; res_r <= res_nxt;
      scale_r <= scale_nxt; rep_r <= rep_nxt; rem_r <= rem_nxt; wrap_r <= wrap_nxt;
      pend_r <= pend_nxt; dr_r <= dr_nxt;
    end
  end

  ps2md_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_data  (ob),
    .busy       (obusy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_uw_range: assert property (@(posedge clk) disable iff (!rst_n)
    uw_r != 2'd3 && uf_r != 2'd3) else $error("unlock index out of range");
  a_proto_gate: assert property (@(posedge clk) disable iff (!rst_n)
    fire && proto_nxt == PROTO_FIVE && proto_r != PROTO_FIVE |-> max_protocol_r == 2'd2)
    else $error("five-button unlocked without permission");
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire && opcode_t'(f_op) == OP_FRAME && dr_r |=> acc_x_r == 0 && acc_y_r == 0)
    else $error("frame did not consume counters");

endmodule
`default_nettype wire

// File: verif/ps2md_checker.sv
// Channel monitor, behavioral predictor and byte checker for the PS/2 mouse device.
`timescale 1ns / 100ps
module ps2md_checker
  import ps2md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [1:0]  cfg_wdata,
  output int               fail_count,
  output int               bytes_owed
);

  typedef struct {
    logic [7:0] data;
    logic       last;
  } host_beat_t;

  host_beat_t owed_q[$];
  logic [7:0] reply_q[$];

  // configuration copy
  logic [1:0] proto_cap;
  logic       squish;

  // device state
  int         cnt_x, cnt_y, cnt_w;
  logic [4:0] btn;
  logic [1:0] proto;
  int         wheel_pos, five_pos;
  int         rate, res;
  logic       scale2, report_en, remote, wrap;
  pend_t      pend;
  logic       have_data;

  assign bytes_owed = owed_q.size();

  // append one byte to the replies of the current item
  function automatic void add_reply(logic [7:0] b);
    reply_q.insert(reply_q.size(), b);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [4:0] shown_buttons();
    if (squish || proto != PROTO_FIVE)
      return {2'b00, |btn[4:2], btn[1:0]};
    return btn;
  endfunction

  function automatic void zero_counts();
    cnt_x = 0;
    cnt_y = 0;
    cnt_w = 0;
  endfunction

  function automatic void drop_unlock();
    wheel_pos = 0;
    five_pos = 0;
  endfunction

  function automatic logic [7:0] id_byte();
    return proto == PROTO_WHEEL ? 8'd3 : (proto == PROTO_FIVE ? 8'd4 : 8'd0);
  endfunction

  function automatic int double_small(int d);
    case (d)
      -5: return -9;
      -4: return -6;
      -3: return -3;
      -2, -1: return -1;
      1, 2: return 1;
      3: return 3;
      4: return 6;
      5: return 9;
      default: return 2 * d;
    endcase
  endfunction

  function automatic void make_packet(logic polled, logic send);
    logic [4:0] vb;
    logic [7:0] b0, b3;
    int dx, dy;
    vb = shown_buttons();
    b0 = {5'b00001, vb[2:0]};
    b3 = 8'h00;
    dx = cnt_x;
    dy = -cnt_y;
    cnt_x = 0;
    cnt_y = 0;
    if (scale2 && !polled) begin
      dx = double_small(dx);
      dy = double_small(dy);
    end
    if (proto == PROTO_FIVE) begin
      dx = clamp(dx, -255, 255);
      dy = clamp(dy, -255, 255);
    end else begin
      if (dx > 255 || dx < -255) b0[6] = 1'b1;
      if (dy > 255 || dy < -255) b0[7] = 1'b1;
    end
    if (dx < 0) b0[4] = 1'b1;
    if (dy < 0) b0[5] = 1'b1;
    if (proto == PROTO_WHEEL) begin
      b3 = 8'(cnt_w);
      cnt_w = 0;
    end else if (proto == PROTO_FIVE) begin
      b3 = {2'b00, vb[4], vb[3], 4'(clamp(cnt_w, -8, 7))};
      cnt_w = 0;
    end
    have_data = 1'b0;
    if (!send) return;
    add_reply(b0);
    add_reply(8'(dx));
    add_reply(8'(dy));
    if (proto == PROTO_WHEEL || proto == PROTO_FIVE) add_reply(b3);
  endfunction

  function automatic void pick_protocol(logic [1:0] p);
    drop_unlock();
    proto = p;
  endfunction

  function automatic void take_resolution(int v);
    drop_unlock();
    zero_counts();
    res = (v == 1 || v == 2 || v == 4 || v == 8) ? v : 4;
  endfunction

  // advance one magic-rate sequence; the index lives in the caller's variable
  function automatic void unlock_advance(int s0, int s1, int s2, ref int pos,
                                         input logic [1:0] p);
    int i;
    int want;
    i = pos > 2 ? 0 : pos;
    want = i == 0 ? s0 : (i == 1 ? s1 : s2);
    if (want != rate) pos = 0;
    else if (i == 2) pick_protocol(p);
    else pos = i + 1;
  endfunction

  function automatic void take_rate(int v);
    zero_counts();
    if (v == 10 || v == 20 || v == 40 || v == 60 || v == 80 || v == 100 || v == 200) begin
      rate = v;
    end else begin
      drop_unlock();
      rate = 100;
    end
    if (proto_cap == 2'd1) begin
      unlock_advance(200, 100, 80, wheel_pos, PROTO_WHEEL);
    end else if (proto_cap == 2'd2) begin
      unlock_advance(200, 100, 80, wheel_pos, PROTO_WHEEL);
      unlock_advance(200, 200, 80, five_pos, PROTO_FIVE);
    end
  endfunction

  function automatic void load_defaults();
    take_resolution(4);
    take_rate(100);
    drop_unlock();
    scale2 = 1'b0;
    report_en = 1'b0;
    remote = 1'b0;
    wrap = 1'b0;
    zero_counts();
  endfunction

  function automatic void host_command(logic [7:0] b);
    pend_t p;
    logic [4:0] vb;
    p = pend;
    if (wrap && b != CMD_DEV_RESET && b != CMD_WRAPOFF) begin
      add_reply(b);
      return;
    end
    add_reply(BYTE_ACK);
    if (p != PEND_NONE) begin
      pend = PEND_NONE;
      if (p == PEND_RES) take_resolution(int'(b));
      else if (p == PEND_RATE) take_rate(int'(b));
      return;
    end
    case (b)
      CMD_SETRES:  pend = PEND_RES;
      CMD_SETRATE: pend = PEND_RATE;
      CMD_SCALE1:  begin drop_unlock(); scale2 = 1'b0; end
      CMD_SCALE2:  begin drop_unlock(); scale2 = 1'b1; end
      CMD_STATUS: begin
        vb = shown_buttons();
        add_reply({1'b0, remote, report_en, scale2, 1'b0, vb[0], vb[2], vb[1]});
        add_reply(8'(res));
        add_reply(8'(rate));
      end
      CMD_STREAM:  begin drop_unlock(); zero_counts(); remote = 1'b0; end
      CMD_READ:    make_packet(1'b1, 1'b1);
      CMD_WRAPOFF: begin drop_unlock(); zero_counts(); wrap = 1'b0; end
      CMD_WRAPON:  begin drop_unlock(); zero_counts(); wrap = 1'b1; end
      CMD_REMOTE:  begin drop_unlock(); zero_counts(); remote = 1'b1; end
      CMD_GETID:   begin add_reply(id_byte()); zero_counts(); end
      CMD_ENABLE:  begin drop_unlock(); zero_counts(); report_en = 1'b1; end
      CMD_DISABLE: begin drop_unlock(); zero_counts(); report_en = 1'b0; end
      CMD_DEFAULT: load_defaults();
      CMD_DEV_RESET: begin
        load_defaults();
        pick_protocol(PROTO_STD);
        add_reply(BYTE_BAT);
        add_reply(id_byte());
        zero_counts();
      end
      default: ;
    endcase
  endfunction

  function automatic void motion_event(int mx, int my, int mw, logic [4:0] bb);
    logic [4:0] old_vis;
    int old_w;
    old_vis = shown_buttons();
    old_w = cnt_w;
    cnt_x = clamp(cnt_x + mx, -AccLimit, AccLimit - 1);
    cnt_y = clamp(cnt_y + my, -AccLimit, AccLimit - 1);
    if (cnt_x != 0 || cnt_y != 0) have_data = 1'b1;
    btn = bb;
    if (shown_buttons() != old_vis) have_data = 1'b1;
    if (proto == PROTO_WHEEL || proto == PROTO_FIVE)
      cnt_w = clamp(cnt_w + mw, -128, 127);
    if (cnt_w != old_w) have_data = 1'b1;
  endfunction

  // predict on every accepted input beat, compare every accepted output beat
  always @(posedge clk) begin
    host_beat_t exp_beat;
    host_beat_t new_beat;
    opcode_t op;
    if (!rst_n) begin
      fail_count = 0;
      proto_cap = 2'd0;
      squish = 1'b0;
      zero_counts();
      btn = '0;
      proto = PROTO_STD;
      drop_unlock();
      rate = 100;
      res = 4;
      scale2 = 1'b0;
      report_en = 1'b0;
      remote = 1'b0;
      wrap = 1'b0;
      pend = PEND_NONE;
      have_data = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_PROTOCOL) proto_cap = cfg_wdata;
        else if (cfg_index == REG_FORCE_SQUISH) squish = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) begin
        op = opcode_t'(in_tuser);
        reply_q.delete();
        case (op)
          OP_HOST:   host_command(in_tdata[7:0]);
          OP_MOTION: motion_event(int'($signed(in_tdata[16:8])),
                                  int'($signed(in_tdata[25:17])),
                                  int'($signed(in_tdata[33:26])),
                                  in_tdata[38:34]);
          OP_FRAME:  if (have_data) make_packet(1'b0, !wrap && !remote && report_en);
          default: ;
        endcase
        foreach (reply_q[k]) begin
          new_beat.data = reply_q[k];
          new_beat.last = (k == reply_q.size() - 1);
          owed_q.insert(owed_q.size(), new_beat);
        end
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: byte %02h last %0b", out_tdata, out_tlast);
        end else begin
          exp_beat = owed_q.pop_front();
          if (out_tdata !== exp_beat.data || out_tlast !== exp_beat.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("beat mismatch: expected %02h/%0b, got %02h/%0b",
                       exp_beat.data, exp_beat.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the PS/2 mouse device testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench
  import ps2md_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;  // host_byte, move_x, move_y, move_wheel, button_bits
  logic [1:0]  in_tuser;  // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata; // out_byte
  logic        out_tlast; // last
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [1:0]  cfg_wdata;
  int          fail_count;
  int          bytes_owed;
  int          out_hold = 0;
  logic        out_took = 1'b0;
  logic        calm;

  ps2_mouse_device_top dut (.*);

  ps2md_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // note each accepted output beat
  always @(posedge clk)
    out_took <= out_tvalid && out_tready;

  // receiver stall: a random hold after each beat, none while calm
  always @(negedge clk) begin
    int hold;
    hold = out_took ? (calm ? 0 : int'($urandom_range(0, 11))) : out_hold;
    if (hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= hold - 1;
    end else begin
      out_tready <= 1'b1;
      out_hold <= 0;
    end
  end

  // drive one item, after a random idle gap unless calm
  task automatic send_item(opcode_t op, logic [7:0] hb, int mx, int my, int mw,
                           logic [4:0] bb);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, bb, 8'(mw), 9'(my), 9'(mx), hb};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic host(logic [7:0] b);
    send_item(OP_HOST, b, 0, 0, 0, 5'd0);
  endtask

  task automatic motion(int mx, int my, int mw, logic [4:0] bb);
    send_item(OP_MOTION, 8'($urandom), mx, my, mw, bb);
  endtask

  task automatic frame_slot();
    send_item(OP_FRAME, 8'($urandom), 0, 0, 0, 5'($urandom));
  endtask

  // drain all owed bytes, let the pipe settle, then write both registers
  task automatic reconfigure(logic [1:0] cap, logic sq);
    in_tvalid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_PROTOCOL;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_index <= REG_FORCE_SQUISH;
    cfg_wdata <= {1'b0, sq};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_move();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 511) - 256;
    return $urandom_range(0, 12) - 6;
  endfunction

  task automatic random_phase(int count);
    logic [7:0] cmds[16];
    int n;
    int kind;
    int which;
    cmds = '{CMD_SETRES, CMD_SCALE1, CMD_SCALE2, CMD_STATUS, CMD_STREAM, CMD_READ,
             CMD_WRAPOFF, CMD_WRAPON, CMD_REMOTE, CMD_GETID, CMD_SETRATE, CMD_ENABLE,
             CMD_DISABLE, CMD_DEFAULT, CMD_DEV_RESET, CMD_ENABLE};
    n = 0;
    while (n < count) begin
      calm = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        motion(rand_move(), rand_move(), $urandom_range(0, 255) - 128, 5'($urandom));
        n++;
      end else if (kind < 50) begin
        frame_slot();
        n++;
      end else if (kind < 60) begin
        // magic rate sequence, either flavor, sometimes broken at the end
        which = $urandom_range(0, 1);
        host(CMD_SETRATE); host(8'd200);
        host(CMD_SETRATE); host(which ? 8'd200 : 8'd100);
        host(CMD_SETRATE); host($urandom_range(0, 4) == 0 ? 8'd60 : 8'd80);
        host(CMD_GETID);
        host(CMD_ENABLE);
        n += 8;
      end else if (kind < 85) begin
        host(cmds[$urandom_range(0, 15)]);
        n++;
      end else if (kind < 95) begin
        host(8'($urandom));
        n++;
      end else begin
        send_item(OP_NONE, 8'($urandom), rand_move(), rand_move(), 0, 5'($urandom));
        n++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_PROTOCOL;
    cfg_wdata = '0;
    calm = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: command set, field extremes, scaling, modes
    host(CMD_DEV_RESET);
    host(CMD_GETID);
    host(CMD_STATUS);
    host(CMD_ENABLE);
    motion(255, 255, 127, 5'h1F);
    frame_slot();
    motion(-256, -256, -128, 5'h00);
    frame_slot();
    host(CMD_SCALE2);
    motion(-5, 5, 1, 5'h04);
    frame_slot();
    host(CMD_SETRES); host(8'd3);
    host(CMD_SETRES); host(8'd8);
    host(CMD_SETRATE); host(8'd77);
    motion(3, -4, 0, 5'h01);
    host(CMD_READ);
    frame_slot();
    host(CMD_WRAPON); host(8'h55); host(CMD_WRAPOFF);
    host(CMD_REMOTE); motion(2, 2, 0, 5'h02); frame_slot();
    host(CMD_STREAM); host(8'h00);
    send_item(OP_NONE, 8'hFF, 255, -256, 127, 5'h1F);
    host(CMD_DISABLE); motion(1, 1, 0, 5'h00); frame_slot();
    host(CMD_DEFAULT); host(CMD_SCALE1);

    reconfigure(2'd1, 1'b0);
    random_phase(50);
    reconfigure(2'd2, 1'b0);
    random_phase(50);
    reconfigure(2'd2, 1'b1);
    random_phase(50);
    reconfigure(2'd3, 1'b0);
    random_phase(40);
    reconfigure(2'd0, 1'b1);
    random_phase(40);

    in_tvalid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
